// ===== sv/eca_pkg.sv =====
// Shared types, constants and functions of the easing curve animator.
// Holds the sine quarter-wave table, built at elaboration, and the curve decoders.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package eca_pkg;

   // Field widths and fixed-point format.
   localparam int TIME_BITS = 24;
   localparam int POS_BITS = 16;
   localparam int FRAC_BITS = 16;
   localparam int SINE_DEPTH = 1024;
   localparam int SINE_LOG2 = $clog2(SINE_DEPTH);
   localparam int KIND_BITS = 4;
   localparam int OUT_BITS = POS_BITS + 2;
   // Unsigned Q format that holds 0 to 1 inclusive.
   localparam int Q_BITS = FRAC_BITS + 1;
   localparam int SINE_BITS = FRAC_BITS + 1;
   localparam int SINE_TAB_BITS = (SINE_DEPTH + 1) * SINE_BITS;

   // Stream payload layout, lowest field first.
   localparam int REQ_FIELD_BITS = 3 * TIME_BITS + 2 * POS_BITS;
   localparam int REQ_DATA_BITS = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS = ((OUT_BITS + 7) / 8) * 8;
   localparam int OFS_TIME_START = 0;
   localparam int OFS_TIME_END = TIME_BITS;
   localparam int OFS_TIME_NOW = 2 * TIME_BITS;
   localparam int OFS_POS_START = 3 * TIME_BITS;
   localparam int OFS_POS_END = 3 * TIME_BITS + POS_BITS;

   // Queue between the front and the back.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_LOG2 = $clog2(QUEUE_DEPTH);

   // Curve codes.
   localparam logic [KIND_BITS-1:0] KIND_CONST = 4'd0;
   localparam logic [KIND_BITS-1:0] KIND_LINEAR = 4'd1;
   localparam logic [KIND_BITS-1:0] KIND_QUAD = 4'd2;
   localparam logic [KIND_BITS-1:0] KIND_INVQUAD = 4'd3;
   localparam logic [KIND_BITS-1:0] KIND_S_S = 4'd4;
   localparam logic [KIND_BITS-1:0] KIND_S = 4'd5;
   localparam logic [KIND_BITS-1:0] KIND_QS_QS = 4'd6;
   localparam logic [KIND_BITS-1:0] KIND_QS = 4'd7;
   localparam logic [KIND_BITS-1:0] KIND_BOUNCE = 4'd8;
   localparam logic [KIND_BITS-1:0] KIND_BOUNCE_QUAD = 4'd9;
   localparam logic [KIND_BITS-1:0] KIND_BOUNCE_INVQUAD = 4'd10;
   localparam logic [KIND_BITS-1:0] KIND_SINE = 4'd11;
   localparam logic [KIND_BITS-1:0] KIND_SINE_S = 4'd12;

   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

   // Operations of one curve unit.
   typedef enum logic [2:0] {
      OP_PASS,
      OP_ZERO,
      OP_QUAD,
      OP_INVQUAD,
      OP_S,
      OP_QS,
      OP_BOUNCE
   } curve_op_type;

   // One classified item as it waits in the queue.
   typedef struct packed {
      logic [TIME_BITS-1:0] num;
      logic [TIME_BITS-1:0] den;
      logic signed [POS_BITS-1:0] pos_start;
      logic signed [POS_BITS-1:0] pos_end;
      logic [KIND_BITS-1:0] kind;
      logic bypass;
      logic take_end;
   } eca_item_type;

   // What travels beside the arithmetic through the back pipeline.
   typedef struct packed {
      logic signed [POS_BITS-1:0] pos_start;
      logic signed [POS_BITS-1:0] pos_end;
      logic [KIND_BITS-1:0] kind;
      logic bypass;
      logic take_end;
   } eca_side_type;

   // Queue status seen by the front and the back.
   typedef struct packed {
      logic full;
      logic empty;
   } eca_qstat_type;

   // Two Taylor factors of a in Q30.
   function automatic longint unsigned taylor_step(longint unsigned term, longint unsigned a);
      longint unsigned t;
      t = (term * a) >> 30;
      t = (t * a) >> 30;
      return t;
   endfunction

   // Quarter-wave sine table in Q(FRAC_BITS), entries 0 to SINE_DEPTH.
   function automatic logic [SINE_TAB_BITS-1:0] build_sine();
      logic [SINE_TAB_BITS-1:0] tab;
      longint unsigned a;
      longint unsigned term;
      longint sum;
      longint entry;
      tab = '0;
      for (int i = 0; i <= SINE_DEPTH; i++) begin
         a = (HALF_PI_Q30 * longint'(i)) >> SINE_LOG2;
         term = a;
         sum = longint'(a);
         term = taylor_step(term, a) / 64'd6;
         sum = sum - longint'(term);
         term = taylor_step(term, a) / 64'd20;
         sum = sum + longint'(term);
         term = taylor_step(term, a) / 64'd42;
         sum = sum - longint'(term);
         term = taylor_step(term, a) / 64'd72;
         sum = sum + longint'(term);
         term = taylor_step(term, a) / 64'd110;
         sum = sum - longint'(term);
         term = taylor_step(term, a) / 64'd156;
         sum = sum + longint'(term);
         term = taylor_step(term, a) / 64'd210;
         sum = sum - longint'(term);
         term = taylor_step(term, a) / 64'd272;
         sum = sum + longint'(term);
         if (sum < 0) begin
            sum = 0;
         end
         if (sum > (longint'(1) << 30)) begin
            sum = longint'(1) << 30;
         end
         entry = (sum + (longint'(1) << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
         tab[i*SINE_BITS +: SINE_BITS] = SINE_BITS'(entry);
      end
      return tab;
   endfunction

   localparam logic [SINE_TAB_BITS-1:0] SINE_TAB = build_sine();

   // Point k of a full wave sampled at 4 * SINE_DEPTH points.
   function automatic logic signed [SINE_BITS:0] full_wave(logic [SINE_LOG2+1:0] k);
      logic [SINE_LOG2-1:0] r;
      logic [SINE_LOG2:0] mirror;
      logic [SINE_BITS-1:0] direct_val;
      logic [SINE_BITS-1:0] mirror_val;
      logic signed [SINE_BITS:0] res;
      r = k[SINE_LOG2-1:0];
      mirror = (SINE_LOG2 + 1)'(SINE_DEPTH) - {1'b0, r};
      direct_val = SINE_TAB[{1'b0, r}*SINE_BITS +: SINE_BITS];
      mirror_val = SINE_TAB[mirror*SINE_BITS +: SINE_BITS];
      case (k[SINE_LOG2+1:SINE_LOG2])
         2'd0: res = $signed({1'b0, direct_val});
         2'd1: res = $signed({1'b0, mirror_val});
         2'd2: res = -$signed({1'b0, direct_val});
         default: res = -$signed({1'b0, mirror_val});
      endcase
      return res;
   endfunction

   // First curve applied to the normalized time.
   function automatic curve_op_type first_op(logic [KIND_BITS-1:0] kind);
      curve_op_type op;
      unique case (kind) inside
         KIND_LINEAR, KIND_SINE: op = OP_PASS;
         KIND_QUAD: op = OP_QUAD;
         KIND_INVQUAD: op = OP_INVQUAD;
         KIND_S_S, KIND_S, KIND_SINE_S: op = OP_S;
         KIND_QS_QS, KIND_QS: op = OP_QS;
         KIND_BOUNCE, KIND_BOUNCE_QUAD, KIND_BOUNCE_INVQUAD: op = OP_BOUNCE;
         default: op = OP_ZERO;
      endcase
      return op;
   endfunction

   // Second curve, applied to the output of the first.
   function automatic curve_op_type second_op(logic [KIND_BITS-1:0] kind);
      curve_op_type op;
      unique case (kind)
         KIND_S_S: op = OP_S;
         KIND_QS_QS: op = OP_QS;
         KIND_BOUNCE_QUAD: op = OP_QUAD;
         KIND_BOUNCE_INVQUAD: op = OP_INVQUAD;
         default: op = OP_PASS;
      endcase
      return op;
   endfunction

endpackage

// ===== sv/eca_queue.sv =====
// Short queue of classified items between the front and the back.
// Depends on eca_pkg for the item type and the depth.
`timescale 1ns / 1ps

module eca_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  eca_pkg::eca_item_type push_item,
   input  logic                  pop,
   output eca_pkg::eca_item_type head_item,
   output eca_pkg::eca_qstat_type stat
);

   eca_pkg::eca_item_type entries_ff [0:eca_pkg::QUEUE_DEPTH-1];
   logic [eca_pkg::QUEUE_LOG2-1:0] wr_ptr_ff, wr_ptr_in;
   logic [eca_pkg::QUEUE_LOG2-1:0] rd_ptr_ff, rd_ptr_in;
   logic [eca_pkg::QUEUE_LOG2:0] count_ff, count_in;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item = entries_ff[rd_ptr_ff];
   assign stat.full = (count_ff == (eca_pkg::QUEUE_LOG2 + 1)'(eca_pkg::QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);

endmodule

// ===== sv/eca_front.sv =====
// Front end: takes an item from the input stream and classifies it.
// Forms the signed time ratio terms and decides the out-of-range results.
// Depends on eca_pkg.
`timescale 1ns / 1ps

module eca_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [eca_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   input  logic [eca_pkg::KIND_BITS-1:0]       req_tuser,
   input  eca_pkg::eca_qstat_type              qstat,
   output logic                                push,
   output eca_pkg::eca_item_type               item
);

   localparam int TB = eca_pkg::TIME_BITS;
   localparam int PB = eca_pkg::POS_BITS;

   logic valid_ff, valid_in;
   logic [TB-1:0] ts_ff, te_ff, tn_ff;
   logic signed [PB-1:0] ps_ff, pe_ff;
   logic [eca_pkg::KIND_BITS-1:0] kind_ff;

   logic signed [TB:0] num_raw, den_raw, num_fix, den_fix;
   logic unknown, too_early, after;

   // The input register takes an item when it is empty or moves on.
   assign req_tready = !valid_ff || !qstat.full;
   assign push = valid_ff && !qstat.full;
   assign valid_in = req_tready ? req_tvalid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready) begin
         ts_ff <= req_tdata[eca_pkg::OFS_TIME_START +: TB];
         te_ff <= req_tdata[eca_pkg::OFS_TIME_END +: TB];
         tn_ff <= req_tdata[eca_pkg::OFS_TIME_NOW +: TB];
         ps_ff <= req_tdata[eca_pkg::OFS_POS_START +: PB];
         pe_ff <= req_tdata[eca_pkg::OFS_POS_END +: PB];
         kind_ff <= req_tuser;
      end
   end

   // Elapsed time and span, with the sign folded into the elapsed time.
   always_comb begin
      num_raw = $signed({1'b0, tn_ff}) - $signed({1'b0, ts_ff});
      den_raw = $signed({1'b0, te_ff}) - $signed({1'b0, ts_ff});
      if (den_raw < 0) begin
         num_fix = -num_raw;
         den_fix = -den_raw;
      end else begin
         num_fix = num_raw;
         den_fix = den_raw;
      end
      unknown = (kind_ff > eca_pkg::KIND_SINE_S);
      too_early = (num_fix <= 0);
      after = (den_fix == 0) || (num_fix >= den_fix);
   end

   // Classified item for the queue.
   always_comb begin
      item.num = num_fix[TB-1:0];
      item.den = den_fix[TB-1:0];
      item.pos_start = ps_ff;
      item.pos_end = pe_ff;
      item.kind = kind_ff;
      item.bypass = unknown || too_early || after;
      item.take_end = !unknown && !too_early && after && (kind_ff < eca_pkg::KIND_BOUNCE);
   end

endmodule

// ===== sv/eca_curve.sv =====
// One easing curve unit: two pipeline stages, one multiplier in each.
// Maps a Q value in [0, 1] through quad, inverse quad, S, inverse-quad S or bounce, passes it, or gives zero.
// Depends on eca_pkg.
`timescale 1ns / 1ps

module eca_curve (
   input  logic                        clock,
   input  logic                        en,
   input  eca_pkg::curve_op_type       op,
   input  logic [eca_pkg::Q_BITS-1:0]  x,
   output logic [eca_pkg::Q_BITS-1:0]  y
);

   localparam int QB = eca_pkg::Q_BITS;
   localparam int FB = eca_pkg::FRAC_BITS;
   localparam logic [QB+1:0] ONE = (QB + 2)'(1) << FB;
   localparam logic [QB+1:0] HALF = (QB + 2)'(1) << (FB - 1);

   eca_pkg::curve_op_type op_a_ff;
   logic [QB-1:0] x_a_ff, sq_a_ff, sq_a_in;
   logic [QB-1:0] y_ff, y_in;

   logic [QB:0] dbl, y1;
   logic [2*QB-1:0] sq_full;

   logic [QB:0] three_m;
   logic [2*QB:0] s_full;
   logic [QB:0] s_val;
   logic [QB+1:0] invq, qs_lo, qs_hi, dbl_a, fold, bnc;

   // First stage: square of x, or of the doubled and centered x.
   always_comb begin
      dbl = {x, 1'b0};
      if (op == eca_pkg::OP_QS) begin
         y1 = ({1'b0, x} <= HALF[QB:0]) ? dbl : dbl - ONE[QB:0];
      end else begin
         y1 = {1'b0, x};
      end
      sq_full = (2*QB)'(y1[QB-1:0]) * (2*QB)'(y1[QB-1:0]) + (2*QB)'(HALF);
      sq_a_in = sq_full[FB +: QB];
   end

   // Second stage: the curve itself.
   always_comb begin
      dbl_a = {1'b0, x_a_ff, 1'b0};
      three_m = QB'(3) * ONE[QB:0] - {x_a_ff, 1'b0};
      s_full = (2*QB + 1)'(sq_a_ff) * (2*QB + 1)'(three_m) + (2*QB + 1)'(HALF);
      s_val = (s_full[2*QB:FB] > (2*QB + 1 - FB)'(ONE)) ? ONE[QB:0] : s_full[FB +: QB + 1];
      invq = dbl_a - (QB + 2)'(sq_a_ff);
      qs_lo = ({x_a_ff, 1'b0, 1'b0} - (QB + 2)'(sq_a_ff)) >> 1;
      qs_hi = ((QB + 2)'(sq_a_ff) >> 1) + HALF;
      fold = (dbl_a >= ONE) ? dbl_a - ONE : ONE - dbl_a;
      bnc = (fold >= ONE) ? '0 : ONE - fold;
      case (op_a_ff)
         eca_pkg::OP_PASS: y_in = x_a_ff;
         eca_pkg::OP_QUAD: y_in = sq_a_ff;
         eca_pkg::OP_INVQUAD: y_in = invq[QB-1:0];
         eca_pkg::OP_S: y_in = s_val[QB-1:0];
         eca_pkg::OP_QS: y_in = ({1'b0, x_a_ff} <= HALF[QB:0]) ? qs_lo[QB-1:0] : qs_hi[QB-1:0];
         eca_pkg::OP_BOUNCE: y_in = bnc[QB-1:0];
         default: y_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         op_a_ff <= op;
         x_a_ff <= x;
         sq_a_ff <= sq_a_in;
         y_ff <= y_in;
      end
   end

   assign y = y_ff;

endmodule

// ===== sv/eca_back.sv =====
// Back end: divider, two curve units, sine lookup and interpolation in one pipeline.
// The whole pipeline advances together whenever its last stage can move on.
// Depends on eca_pkg and eca_curve.
`timescale 1ns / 1ps

module eca_back (
   input  logic                               clock,
   input  logic                               reset,
   input  eca_pkg::eca_item_type              head_item,
   input  eca_pkg::eca_qstat_type             qstat,
   output logic                               pop,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [eca_pkg::RSP_DATA_BITS-1:0]  rsp_tdata
);

   localparam int TB = eca_pkg::TIME_BITS;
   localparam int FB = eca_pkg::FRAC_BITS;
   localparam int QB = eca_pkg::Q_BITS;
   localparam int PB = eca_pkg::POS_BITS;
   localparam int SB = eca_pkg::SINE_BITS;
   localparam int SL = eca_pkg::SINE_LOG2;
   // Stage numbers.
   localparam int ST_DIV = FB;
   localparam int ST_CA = ST_DIV + 2;
   localparam int ST_CB = ST_CA + 2;
   localparam int ST_SN1 = ST_CB + 1;
   localparam int ST_SN2 = ST_SN1 + 1;
   localparam int ST_W = ST_SN2 + 1;
   localparam int ST_MUL = ST_W + 1;
   localparam int LAST = ST_MUL + 1;
   localparam int PF_BITS = QB + SL + 2;
   localparam int SP_BITS = SB + 2 + FB + 1;
   localparam int IP_BITS = PB + 1 + SB + 1;
   localparam int V_BITS = PB + FB + 4;

   logic en;
   logic valid_ff [0:LAST];
   eca_pkg::eca_side_type side_ff [0:LAST];
   eca_pkg::eca_side_type head_side;

   logic [TB-1:0] rem_ff [0:ST_DIV];
   logic [TB-1:0] den_ff [0:ST_DIV];
   logic [FB-1:0] quo_ff [0:ST_DIV];

   logic [QB-1:0] curve_a, curve_b;

   logic [PF_BITS-1:0] pf;
   logic [SL+2:0] idx;
   logic [SL+1:0] k_a, k_b;
   logic signed [SB:0] sa_ff, sb_ff, sa2_ff;
   logic [FB-1:0] fr_ff;
   logic [QB-1:0] sx_ff, sx2_ff;
   logic signed [SP_BITS-1:0] sprod_ff, sprod_in;
   logic signed [SP_BITS-1:0] sround;
   logic signed [SB:0] w_ff, w_in;
   logic signed [IP_BITS-1:0] iprod_ff, iprod_in;
   logic signed [V_BITS-1:0] v_sum, v_round;
   logic signed [PB:0] dpos;
   logic [eca_pkg::OUT_BITS-1:0] res_ff, res_in;

   // The pipeline moves when its output stage is empty or being taken.
   assign en = !valid_ff[LAST] || rsp_tready;
   assign pop = en && !qstat.empty;

   always_comb begin
      head_side.pos_start = head_item.pos_start;
      head_side.pos_end = head_item.pos_end;
      head_side.kind = head_item.kind;
      head_side.bypass = head_item.bypass;
      head_side.take_end = head_item.take_end;
   end

   // Valid bits of every stage.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= LAST; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else if (en) begin
         valid_ff[0] <= !qstat.empty;
         for (int i = 1; i <= LAST; i++) begin
            valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   // Side information travels with each item.
   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= head_side;
         for (int i = 1; i <= LAST; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   // Restoring divider, one quotient bit per stage.
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0] <= head_item.num;
         den_ff[0] <= head_item.den;
         quo_ff[0] <= '0;
      end
   end

   for (genvar g = 1; g <= ST_DIV; g++) begin : g_div
      logic [TB:0] r2, diff;
      logic ge;
      always_comb begin
         r2 = {rem_ff[g-1], 1'b0};
         diff = r2 - {1'b0, den_ff[g-1]};
         ge = (r2 >= {1'b0, den_ff[g-1]});
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[g] <= ge ? diff[TB-1:0] : r2[TB-1:0];
            den_ff[g] <= den_ff[g-1];
            quo_ff[g] <= {quo_ff[g-1][FB-2:0], ge};
         end
      end
   end

   // Two curve units in a row.
   eca_curve u_curve_a (
      .clock (clock),
      .en    (en),
      .op    (eca_pkg::first_op(side_ff[ST_DIV].kind)),
      .x     ({1'b0, quo_ff[ST_DIV]}),
      .y     (curve_a)
   );

   eca_curve u_curve_b (
      .clock (clock),
      .en    (en),
      .op    (eca_pkg::second_op(side_ff[ST_CA].kind)),
      .x     (curve_a),
      .y     (curve_b)
   );

   // Sine lookup: the two neighboring samples and the fraction between them.
   always_comb begin
      pf = PF_BITS'(curve_b) << (SL + 2);
      idx = pf[FB +: SL + 3];
      k_a = idx[SL+1:0];
      k_b = k_a + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sa_ff <= eca_pkg::full_wave(k_a);
         sb_ff <= eca_pkg::full_wave(k_b);
         fr_ff <= pf[FB-1:0];
         sx_ff <= curve_b;
      end
   end

   // Slope times fraction.
   assign sprod_in = SP_BITS'(sb_ff - sa_ff) * $signed({1'b0, fr_ff});

   always_ff @(posedge clock) begin
      if (en) begin
         sprod_ff <= sprod_in;
         sa2_ff <= sa_ff;
         sx2_ff <= sx_ff;
      end
   end

   // Rounded interpolation for the sine curves, zero for the constant curve, plain value otherwise.
   always_comb begin
      if (sprod_ff >= 0) begin
         sround = (sprod_ff + (SP_BITS'(1) <<< (FB - 1))) >>> FB;
      end else begin
         sround = -((-sprod_ff + (SP_BITS'(1) <<< (FB - 1))) >>> FB);
      end
      if (side_ff[ST_SN2].kind == eca_pkg::KIND_SINE
          || side_ff[ST_SN2].kind == eca_pkg::KIND_SINE_S) begin
         w_in = sa2_ff + sround[SB:0];
      end else if (side_ff[ST_SN2].kind == eca_pkg::KIND_CONST) begin
         w_in = '0;
      end else begin
         w_in = $signed({1'b0, sx2_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         w_ff <= w_in;
      end
   end

   // Position span times the warped time.
   always_comb begin
      dpos = $signed({side_ff[ST_W].pos_end[PB-1], side_ff[ST_W].pos_end})
             - $signed({side_ff[ST_W].pos_start[PB-1], side_ff[ST_W].pos_start});
      iprod_in = IP_BITS'(dpos) * IP_BITS'(w_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         iprod_ff <= iprod_in;
      end
   end

   // Add the start position and round half away from zero; a bypassed item takes its start or end position.
   always_comb begin
      v_sum = (V_BITS'(side_ff[ST_MUL].pos_start) <<< FB) + V_BITS'(iprod_ff);
      if (v_sum >= 0) begin
         v_round = (v_sum + (V_BITS'(1) <<< (FB - 1))) >>> FB;
      end else begin
         v_round = -((-v_sum + (V_BITS'(1) <<< (FB - 1))) >>> FB);
      end
      if (side_ff[ST_MUL].bypass) begin
         res_in = side_ff[ST_MUL].take_end ? eca_pkg::OUT_BITS'(side_ff[ST_MUL].pos_end)
                                           : eca_pkg::OUT_BITS'(side_ff[ST_MUL].pos_start);
      end else begin
         res_in = v_round[eca_pkg::OUT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   assign rsp_tvalid = valid_ff[LAST];
   assign rsp_tdata = eca_pkg::RSP_DATA_BITS'(res_ff);

endmodule

// ===== sv/easing_curve_animator_top.sv =====
// Top level of the easing curve animator: front end, queue and back pipeline.
// Depends on eca_pkg, eca_front, eca_queue and eca_back.
`timescale 1ns / 1ps

// The block takes one item per clock while the queue is not full, and returns
// one position per item, in order. An accepted item passes the input register
// and the queue, then the restoring divider, which forms one quotient bit per
// pipeline stage, followed by two curve units, the sine lookup and the
// interpolation multiplier. The input side keeps accepting while a result
// waits, until the four-entry queue and the input register are full.
module easing_curve_animator_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // time_start, time_end, time_now, pos_start, pos_end
   input  logic [eca_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // curve_kind
   input  logic [eca_pkg::KIND_BITS-1:0]      req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // position, zero fill
   output logic [eca_pkg::RSP_DATA_BITS-1:0]  rsp_tdata
);

   eca_pkg::eca_qstat_type qstat;
   eca_pkg::eca_item_type push_item, head_item;
   logic push, pop;

   // Input register and classification.
   eca_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .qstat      (qstat),
      .push       (push),
      .item       (push_item)
   );

   // Queue between the two halves.
   eca_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .stat      (qstat)
   );

   // Arithmetic pipeline and output register.
   eca_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_item  (head_item),
      .qstat      (qstat),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== sv/eca_checker.sv =====
// Port-level checks of the easing curve animator, bound to the top level.
// Depends on eca_pkg and easing_curve_animator_top.
`timescale 1ns / 1ps

module eca_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic [eca_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   input logic [eca_pkg::KIND_BITS-1:0]      req_tuser,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [eca_pkg::RSP_DATA_BITS-1:0]  rsp_tdata
);

   // A stalled result stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // A stalled result keeps its value.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result changed while stalled");

   // Nothing comes out right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered after reset");

   // The block is ready for an item right after reset.
   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("input not ready after reset");

endmodule

bind easing_curve_animator_top eca_checker u_checker (.*);

// ===== dv/testbench.sv =====
// Self-checking testbench of the easing curve animator: directed and random items.
// Predicts each position with its own fixed-point curve model; depends on eca_pkg and easing_curve_animator_top.
`timescale 1ns / 1ps

// Expected positions of accepted items, in order, and the check of each result.
class position_scoreboard;
   logic signed [eca_pkg::OUT_BITS-1:0] pending[$];
   int errors;

   function void note_item(logic signed [eca_pkg::OUT_BITS-1:0] position);
      pending.push_back(position);
   endfunction

   function void check_result(logic signed [eca_pkg::OUT_BITS-1:0] position);
      logic signed [eca_pkg::OUT_BITS-1:0] want;
      if (pending.size() == 0) begin
         $display("%0t: unexpected result, expected none, actual %0d", $time, position);
         errors++;
      end else begin
         want = pending.pop_front();
         if (want !== position) begin
            $display("%0t: position mismatch, expected %0d, actual %0d",
                     $time, want, position);
            errors++;
         end
      end
   endfunction
endclass

module testbench;
   import eca_pkg::*;

   localparam longint ONE_Q = longint'(1) << FRAC_BITS;
   localparam int SIM_LIMIT = 2000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic [KIND_BITS-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;

   longint quarter_sine[SINE_DEPTH + 1];
   position_scoreboard board;
   int cycle_count = 0;

   easing_curve_animator_top dut (.*);

   always #5 clock = ~clock;

   // Quarter-wave table by a truncated Taylor series in Q30.
   function automatic void fill_sine();
      longint unsigned a, term;
      longint sum;
      for (int i = 0; i <= SINE_DEPTH; i++) begin
         a = HALF_PI_Q30 * longint'(i) / SINE_DEPTH;
         term = a;
         sum = longint'(a);
         for (int k = 1; k <= 8; k++) begin
            term = (term * a) >> 30;
            term = ((term * a) >> 30) / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) sum -= longint'(term);
            else sum += longint'(term);
         end
         if (sum < 0) sum = 0;
         if (sum > (longint'(1) << 30)) sum = longint'(1) << 30;
         quarter_sine[i] = (sum + (longint'(1) << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
      end
   endfunction

   function automatic longint round_away(longint v);
      longint half;
      half = longint'(1) << (FRAC_BITS - 1);
      if (v >= 0) return (v + half) >>> FRAC_BITS;
      return -((-v + half) >>> FRAC_BITS);
   endfunction

   function automatic longint q_mul(longint a, longint b);
      return (a * b + (ONE_Q >>> 1)) >>> FRAC_BITS;
   endfunction

   function automatic longint unit_clamp(longint v);
      if (v < 0) return 0;
      if (v > ONE_Q) return ONE_Q;
      return v;
   endfunction

   function automatic longint ease_s(longint x);
      return unit_clamp(q_mul(q_mul(x, x), 3 * ONE_Q - 2 * x));
   endfunction

   function automatic longint ease_qs(longint x);
      longint y;
      if (x <= (ONE_Q >>> 1)) begin
         y = 2 * x;
         return unit_clamp((2 * y - q_mul(y, y)) >>> 1);
      end
      y = 2 * x - ONE_Q;
      return unit_clamp((q_mul(y, y) >>> 1) + (ONE_Q >>> 1));
   endfunction

   function automatic longint ease_bounce(longint x);
      longint d;
      d = 2 * x - ONE_Q;
      if (d < 0) d = -d;
      return unit_clamp(ONE_Q - d);
   endfunction

   function automatic longint wave_point(longint k);
      longint r;
      if (k >= 4 * SINE_DEPTH) k -= 4 * SINE_DEPTH;
      r = k % SINE_DEPTH;
      case (k / SINE_DEPTH)
         0: return quarter_sine[r];
         1: return quarter_sine[SINE_DEPTH - r];
         2: return -quarter_sine[r];
         default: return -quarter_sine[SINE_DEPTH - r];
      endcase
   endfunction

   function automatic longint ease_sine(longint x);
      longint pf, lo, hi;
      pf = x * 4 * SINE_DEPTH;
      lo = wave_point(pf >>> FRAC_BITS);
      hi = wave_point((pf >>> FRAC_BITS) + 1);
      return lo + round_away((hi - lo) * (pf & (ONE_Q - 1)));
   endfunction

   function automatic longint warp_time(logic [KIND_BITS-1:0] kind, longint x);
      case (kind)
         KIND_LINEAR: return x;
         KIND_QUAD: return q_mul(x, x);
         KIND_INVQUAD: return 2 * x - q_mul(x, x);
         KIND_S_S: return ease_s(ease_s(x));
         KIND_S: return ease_s(x);
         KIND_QS_QS: return ease_qs(ease_qs(x));
         KIND_QS: return ease_qs(x);
         KIND_BOUNCE: return ease_bounce(x);
         KIND_BOUNCE_QUAD: return q_mul(ease_bounce(x), ease_bounce(x));
         KIND_BOUNCE_INVQUAD: return 2 * ease_bounce(x) - q_mul(ease_bounce(x), ease_bounce(x));
         KIND_SINE: return ease_sine(x);
         KIND_SINE_S: return ease_sine(ease_s(x));
         default: return 0;
      endcase
   endfunction

   // Expected position of one item.
   function automatic logic signed [OUT_BITS-1:0] predict_position(
         logic [TIME_BITS-1:0] ts, logic [TIME_BITS-1:0] te, logic [TIME_BITS-1:0] tn,
         logic signed [POS_BITS-1:0] ps, logic signed [POS_BITS-1:0] pe,
         logic [KIND_BITS-1:0] kind);
      longint num, den, t, res;
      num = longint'(tn) - longint'(ts);
      den = longint'(te) - longint'(ts);
      if (den < 0) begin
         den = -den;
         num = -num;
      end
      if (kind > KIND_SINE_S || num <= 0) res = ps;
      else if (den == 0 || num >= den) res = (kind >= KIND_BOUNCE) ? ps : pe;
      else begin
         t = (num << FRAC_BITS) / den;
         res = round_away(longint'(ps) * ONE_Q
                          + (longint'(pe) - longint'(ps)) * warp_time(kind, t));
      end
      return OUT_BITS'(res);
   endfunction

   // Hands one item to the block and notes its expected position.
   task automatic send_item(logic [TIME_BITS-1:0] ts, logic [TIME_BITS-1:0] te,
                            logic [TIME_BITS-1:0] tn, logic signed [POS_BITS-1:0] ps,
                            logic signed [POS_BITS-1:0] pe, logic [KIND_BITS-1:0] kind,
                            bit no_gap);
      int gap;
      gap = no_gap ? 0 : $urandom_range(13);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= REQ_DATA_BITS'({pe, ps, tn, te, ts});
      req_tuser <= kind;
      do @(posedge clock); while (!req_tready);
      board.note_item(predict_position(ts, te, tn, ps, pe, kind));
   endtask

   // Random item; most fall inside a short span so the curves are exercised.
   task automatic send_random(bit no_gap);
      logic [TIME_BITS-1:0] ts, te, tn;
      int span;
      ts = TIME_BITS'($urandom);
      case ($urandom_range(9))
         0: begin
            te = TIME_BITS'($urandom);
            tn = TIME_BITS'($urandom);
         end
         1: begin
            te = ts;
            tn = TIME_BITS'(ts + $urandom_range(2) - 1);
         end
         2: begin
            span = $urandom_range(16777215, 1);
            te = TIME_BITS'(ts + span);
            tn = TIME_BITS'(ts + $urandom_range(span));
         end
         default: begin
            span = $urandom_range(4096, 1);
            te = TIME_BITS'(ts + span);
            tn = TIME_BITS'(ts + $urandom_range(span + 2) - 1);
            if ($urandom_range(5) == 0) begin
               te = ts;
               ts = TIME_BITS'(ts + span);
               tn = TIME_BITS'(te + $urandom_range(span + 2) - 1);
            end
         end
      endcase
      send_item(ts, te, tn, POS_BITS'($urandom), POS_BITS'($urandom),
                KIND_BITS'($urandom_range(15)), no_gap);
   endtask

   // Result side: random stalls, stretches with none.
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         stall = (cycle_count / 3000) % 4 == 1 ? 0 : $urandom_range(13);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         board.check_result(rsp_tdata[OUT_BITS-1:0]);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= SIM_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      board = new();
      fill_sine();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: every curve inside the span, then the boundaries.
      for (int k = 0; k < 16; k++)
         send_item(24'd100, 24'd1100, 24'd100 + 24'(37 * k + 61), -16'sd32768, 16'sd32767,
                   KIND_BITS'(k), 1'b0);
      send_item(24'd500, 24'd900, 24'd400, 16'sd5, 16'sd9, KIND_LINEAR, 1'b0);
      send_item(24'd500, 24'd900, 24'd900, 16'sd5, 16'sd9, KIND_QUAD, 1'b0);
      send_item(24'd500, 24'd900, 24'd950, 16'sd5, 16'sd9, KIND_BOUNCE, 1'b0);
      send_item(24'd700, 24'd700, 24'd701, 16'sd5, 16'sd9, KIND_S, 1'b0);
      send_item(24'd700, 24'd700, 24'd700, 16'sd5, 16'sd9, KIND_S, 1'b0);
      send_item(24'd900, 24'd100, 24'd300, 16'sd32767, -16'sd32768, KIND_SINE, 1'b1);
      send_item(24'hFFFFFF, 24'd0, 24'd1, 16'sd0, -16'sd1, KIND_LINEAR, 1'b1);
      send_item(24'd0, 24'hFFFFFF, 24'hFFFFFE, 16'sd32767, -16'sd32768, KIND_SINE_S, 1'b1);
      send_item(24'd0, 24'hFFFFFF, 24'd1, -16'sd1, 16'sd32767, KIND_QS_QS, 1'b1);

      // Hold off until everything sent so far has come back.
      req_tvalid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      @(posedge clock);

      for (int n = 0; n < 1050; n++)
         send_random((n / 150) % 3 == 2);
      req_tvalid <= 1'b0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
